### rtl/core/mandel_pkg.sv
// Package: widths, reset constants and item types for the Mandelbrot escape-time unit
`timescale 1ns / 1ps

package mandel_pkg;

    localparam int ITER_WIDTH     = 10;
    localparam int FRAC_BITS_DEF  = 28;
    localparam int MAX_ITER_RESET = 50;

    localparam int C_WIDTH = 32;
    localparam int H_WIDTH = 32;
    localparam int Z_WIDTH = 64;
    localparam int P_WIDTH = 128;

    typedef struct packed {
        logic signed [C_WIDTH-1:0] c_real;
        logic signed [C_WIDTH-1:0] c_imag;
    } in_item_t;

    typedef struct packed {
        logic [ITER_WIDTH-1:0] iter_count;
        logic                  escaped;
    } out_item_t;

endpackage

### rtl/core/mandelbrot_escape_time.sv
// Mandelbrot escape-time unit: shared 32x32 multiplier under a small sequencer
// A zero limit shows the result in the cycle after accept; otherwise each iteration runs
// S_RI, S_UPDR, S_UPDI, S_MAG, S_SQR, S_SQI, S_CHK in turn until escape or the limit.
// Each 64x64 product takes four passes through the one 32x32 multiplier plus a final
// accumulate step. One item at a time: no new item until the current result is taken.
// Reset: rst_n asynchronous, active low; block idle, max_iter = 50.
`timescale 1ns / 1ps

module mandelbrot_escape_time #(
    parameter int FRAC_BITS = mandel_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  mandel_pkg::in_item_t              in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output mandel_pkg::out_item_t             out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mandel_pkg::ITER_WIDTH-1:0] cfg_data
);

    localparam int IW = mandel_pkg::ITER_WIDTH;
    localparam int CW = mandel_pkg::C_WIDTH;
    localparam int HW = mandel_pkg::H_WIDTH;
    localparam int ZW = mandel_pkg::Z_WIDTH;
    localparam int PW = mandel_pkg::P_WIDTH;
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_FIRST = 3'd0;
    localparam logic [STEP_W-1:0] STEP_LO    = 3'd1;
    localparam logic [STEP_W-1:0] STEP_MID0  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_MID1  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_LAST  = 3'd4;
    localparam logic [PW-1:0] ESC_LIMIT = {{(PW-1){1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RI   = 9'b000000010,
        S_UPDR = 9'b000000100,
        S_UPDI = 9'b000001000,
        S_MAG  = 9'b000010000,
        S_SQR  = 9'b000100000,
        S_SQI  = 9'b001000000,
        S_CHK  = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [IW-1:0]       lim_reg, lim_next;
    logic [IW-1:0]       max_iter_reg;

    logic [CW-1:0]       cr_reg, cr_next;
    logic [CW-1:0]       ci_reg, ci_next;
    logic [ZW-1:0]       zr_reg, zr_next;
    logic [ZW-1:0]       zi_reg, zi_next;
    logic [ZW-1:0]       mr_reg, mr_next;
    logic [ZW-1:0]       mi_reg, mi_next;
    logic                sd_reg, sd_next;
    logic [PW-1:0]       rr_reg, rr_next;
    logic [PW-1:0]       ii_reg, ii_next;
    logic [PW-1:0]       ri_reg, ri_next;
    logic [PW-1:0]       acc_reg, acc_next;
    logic [ZW-1:0]       pp_reg, pp_next;
    mandel_pkg::out_item_t out_reg, out_next;

    logic [ZW-1:0]       a_op, b_op;
    logic [HW-1:0]       a_half, b_half;
    logic [PW-1:0]       part;
    logic [PW-1:0]       diff_rr_ii;
    logic [PW-1:0]       ri_dbl, ri_sgn;
    logic [PW-1:0]       sq_sum;
    logic [ZW-1:0]       cr_ext, ci_ext;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    // shared multiplier: operand pair by state, halves by step
    always_comb
    begin
        case (state_reg)
            S_SQR:
            begin
                a_op = mr_reg;
                b_op = mr_reg;
            end
            S_SQI:
            begin
                a_op = mi_reg;
                b_op = mi_reg;
            end
            default:
            begin
                a_op = mr_reg;
                b_op = mi_reg;
            end
        endcase
    end

    assign a_half  = step_reg[1] ? a_op[ZW-1:HW] : a_op[HW-1:0];
    assign b_half  = step_reg[0] ? b_op[ZW-1:HW] : b_op[HW-1:0];
    assign pp_next = a_half * b_half;

    always_comb
    begin
        case (step_reg)
            STEP_LO:              part = {{(PW-ZW){1'b0}}, pp_reg};
            STEP_MID0, STEP_MID1: part = {{(PW-ZW-HW){1'b0}}, pp_reg, {HW{1'b0}}};
            STEP_LAST:            part = {pp_reg, {(PW-ZW){1'b0}}};
            default:              part = '0;
        endcase
    end

    assign acc_next = (step_reg == STEP_FIRST) ? '0 : (acc_reg + part);

    assign cr_ext     = {{(ZW-CW){cr_reg[CW-1]}}, cr_reg};
    assign ci_ext     = {{(ZW-CW){ci_reg[CW-1]}}, ci_reg};
    assign diff_rr_ii = rr_reg - ii_reg;
    assign ri_dbl     = {ri_reg[PW-2:0], 1'b0};
    assign ri_sgn     = sd_reg ? (PW'(0) - ri_dbl) : ri_dbl;
    assign sq_sum     = rr_reg + ii_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        lim_next   = lim_reg;
        cr_next    = cr_reg;
        ci_next    = ci_reg;
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        mr_next    = mr_reg;
        mi_next    = mi_reg;
        sd_next    = sd_reg;
        rr_next    = rr_reg;
        ii_next    = ii_reg;
        ri_next    = ri_reg;
        out_next   = out_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cr_next   = in_data.c_real;
                    ci_next   = in_data.c_imag;
                    mr_next   = '0;
                    mi_next   = '0;
                    sd_next   = 1'b0;
                    rr_next   = '0;
                    ii_next   = '0;
                    idx_next  = '0;
                    step_next = STEP_FIRST;
                    lim_next  = max_iter_reg;
                    if (max_iter_reg == '0)
                    begin
                        out_next.iter_count = '0;
                        out_next.escaped    = 1'b0;
                        state_next          = S_DONE;
                    end
                    else
                    begin
                        state_next = S_RI;
                    end
                end
            end
            S_RI, S_SQR, S_SQI:
            begin
                if (step_reg == STEP_LAST)
                begin
                    step_next = STEP_FIRST;
                    case (state_reg)
                        S_RI:
                        begin
                            ri_next    = acc_next;
                            state_next = S_UPDR;
                        end
                        S_SQR:
                        begin
                            rr_next    = acc_next;
                            state_next = S_SQI;
                        end
                        default:
                        begin
                            ii_next    = acc_next;
                            state_next = S_CHK;
                        end
                    endcase
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_UPDR:
            begin
                zr_next    = diff_rr_ii[FRAC_BITS +: ZW] + cr_ext;
                state_next = S_UPDI;
            end
            S_UPDI:
            begin
                zi_next    = ri_sgn[FRAC_BITS +: ZW] + ci_ext;
                state_next = S_MAG;
            end
            S_MAG:
            begin
                mr_next    = zr_reg[ZW-1] ? (ZW'(0) - zr_reg) : zr_reg;
                mi_next    = zi_reg[ZW-1] ? (ZW'(0) - zi_reg) : zi_reg;
                sd_next    = zr_reg[ZW-1] ^ zi_reg[ZW-1];
                state_next = S_SQR;
            end
            S_CHK:
            begin
                if (sq_sum >= ESC_LIMIT)
                begin
                    out_next.iter_count = idx_reg;
                    out_next.escaped    = 1'b1;
                    state_next          = S_DONE;
                end
                else if (idx_reg == (lim_reg - IW'(1)))
                begin
                    out_next.iter_count = lim_reg;
                    out_next.escaped    = 1'b0;
                    state_next          = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_RI;
                end
            end
            S_DONE:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_reg     <= STEP_FIRST;
            idx_reg      <= '0;
            lim_reg      <= '0;
            max_iter_reg <= IW'(mandel_pkg::MAX_ITER_RESET);
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
            lim_reg   <= lim_next;
            if (cfg_valid)
            begin
                max_iter_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cr_reg  <= cr_next;
        ci_reg  <= ci_next;
        zr_reg  <= zr_next;
        zi_reg  <= zi_next;
        mr_reg  <= mr_next;
        mi_reg  <= mi_next;
        sd_reg  <= sd_next;
        rr_reg  <= rr_next;
        ii_reg  <= ii_next;
        ri_reg  <= ri_next;
        acc_reg <= acc_next;
        pp_reg  <= pp_next;
        out_reg <= out_next;
    end

    // checks
    a_busy_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is pending");

    a_accept_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (max_iter_reg != '0)) |=> !out_valid)
        else $error("result shown right after accepting a nonzero-limit item");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_LAST)
        else $error("multiply step counter out of range");

    a_esc_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.escaped) |-> (out_data.iter_count < lim_reg))
        else $error("escape index not below the limit");

    a_noesc_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.escaped) |-> (out_data.iter_count == lim_reg))
        else $error("non-escaped count differs from the limit");

endmodule
